// ----- hdl/tfi_pkg.sv -----
// Package with shared constants and types of the two-input fuzzy inference core.
package tfi_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_X_LOW  = 3'd0;
    localparam logic [2:0] CFG_X_MID  = 3'd1;
    localparam logic [2:0] CFG_X_HIGH = 3'd2;
    localparam logic [2:0] CFG_Y_LOW  = 3'd3;
    localparam logic [2:0] CFG_Y_MID  = 3'd4;
    localparam logic [2:0] CFG_Y_HIGH = 3'd5;

    // Breakpoint reset values.
    localparam logic [14:0] RST_X_LOW  = 15'd14080;
    localparam logic [14:0] RST_X_MID  = 15'd17920;
    localparam logic [14:0] RST_X_HIGH = 15'd23040;
    localparam logic [15:0] RST_Y_LOW  = 16'd2560;
    localparam logic [15:0] RST_Y_MID  = 16'd6400;
    localparam logic [15:0] RST_Y_HIGH = 16'd8960;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // Output singletons.
    localparam logic [6:0] SING_LOW  = 7'd12;
    localparam logic [6:0] SING_MID  = 7'd50;
    localparam logic [6:0] SING_HIGH = 7'd85;

    // Divider geometry: membership ramps and the score.
    localparam int MEM_DEN_W   = 16;
    localparam int SCORE_DEN_W = 17;
    localparam int QUO_W       = 15;

    // Position of a value against its three breakpoints.
    typedef struct packed {
        logic le_l;
        logic le_m;
        logic le_h;
    } t_cmp;

    // Breakpoint comparison and the ramp division that the value needs.
    typedef struct packed {
        t_cmp        c;
        logic [15:0] d;
        logic [15:0] s;
    } t_sel;

endpackage

// ----- hdl/tfi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
module tfi_div
    import tfi_pkg::*;
#(
    parameter int NL = 1,
    parameter int WD = MEM_DEN_W,
    parameter int WQ = QUO_W,
    parameter int WS = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [NL-1:0][WD+WQ-1:0]      i_num,
    input  logic [NL-1:0][WD-1:0]         i_den,
    input  logic [WS-1:0]                 i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [NL-1:0][WQ-1:0]         o_quo,
    output logic [WS-1:0]                 o_side
);

    logic [WQ-1:0]                 r_v;
    logic [WQ-1:0][NL-1:0][WD-1:0] r_rem;
    logic [WQ-1:0][NL-1:0][WQ-1:0] r_low;
    logic [WQ-1:0][NL-1:0][WD-1:0] r_den;
    logic [WQ-1:0][WS-1:0]         r_side;

    logic [WQ-1:0]                 s_v;
    logic [WQ-1:0][NL-1:0][WD-1:0] s_rem;
    logic [WQ-1:0][NL-1:0][WQ-1:0] s_low;
    logic [WQ-1:0][NL-1:0][WD-1:0] s_den;
    logic [WQ-1:0][WS-1:0]         s_side;

    logic [WQ-1:0][NL-1:0][WD-1:0] n_rem;
    logic [WQ-1:0][NL-1:0][WQ-1:0] n_low;
    logic [WQ:0]                   en;

    // Stage inputs: the ports feed stage zero, each stage feeds the next.
    always_comb begin
        s_v[0]    = i_valid;
        s_side[0] = i_side;
        s_den[0]  = i_den;
        for (int l = 0; l < NL; l++) begin
            s_rem[0][l] = i_num[l][WD+WQ-1:WQ];
            s_low[0][l] = i_num[l][WQ-1:0];
        end
        for (int k = 1; k < WQ; k++) begin
            s_v[k]    = r_v[k-1];
            s_side[k] = r_side[k-1];
            s_den[k]  = r_den[k-1];
            s_rem[k]  = r_rem[k-1];
            s_low[k]  = r_low[k-1];
        end
    end

    // The dividend's low bits shift out on top while quotient bits shift in below.
    always_comb begin
        logic [WD:0] t;
        logic        ge;
        for (int k = 0; k < WQ; k++) begin
            for (int l = 0; l < NL; l++) begin
                t  = {s_rem[k][l], s_low[k][l][WQ-1]};
                ge = (t >= {1'b0, s_den[k][l]});
                n_rem[k][l] = ge ? WD'(t - {1'b0, s_den[k][l]}) : t[WD-1:0];
                n_low[k][l] = {s_low[k][l][WQ-2:0], ge};
            end
        end
    end

    // A stage takes new data when it is empty or its content moves on.
    always_comb begin
        en[WQ] = i_ready;
        for (int k = WQ - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < WQ; k++) begin
                if (en[k]) begin
                    r_v[k] <= s_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < WQ; k++) begin
            if (en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_den[k]  <= s_den[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[WQ-1];
    assign o_quo   = r_low[WQ-1];
    assign o_side  = r_side[WQ-1];

endmodule

// ----- hdl/two_input_fuzzy_inference_core.sv -----
// Two-input Mamdani fuzzy inference core with weighted-average defuzzification.
//
//  Channel   Handshake            Payload
//  input     i_valid / o_ready    i_x_value, i_y_value
//  output    o_valid / i_ready    o_*_class_strength, o_crisp_score
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One transaction enters per cycle while o_ready is high. The pipeline holds an
// input stage, the 15-stage membership divider, rule and weighting stages, and
// the 15-stage score divider. Reset is synchronous; it empties the pipeline and
// restores the breakpoints. Every stage has its own valid bit and moves when
// empty or when its successor moves, so a stalled output only holds back full stages.
module two_input_fuzzy_inference_core
    import tfi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [14:0] i_x_value,
    input  logic [15:0] i_y_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_low_class_strength,
    output logic [15:0] o_mid_class_strength,
    output logic [15:0] o_high_class_strength,
    output logic [14:0] o_crisp_score,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [14:0] r_x_low, r_x_mid, r_x_high;
    logic [15:0] r_y_low, r_y_mid, r_y_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= RST_X_LOW;
            r_x_mid  <= RST_X_MID;
            r_x_high <= RST_X_HIGH;
            r_y_low  <= RST_Y_LOW;
            r_y_mid  <= RST_Y_MID;
            r_y_high <= RST_Y_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_LOW:  r_x_low  <= i_cfg_data[14:0];
                CFG_X_MID:  r_x_mid  <= i_cfg_data[14:0];
                CFG_X_HIGH: r_x_high <= i_cfg_data[14:0];
                CFG_Y_LOW:  r_y_low  <= i_cfg_data;
                CFG_Y_MID:  r_y_mid  <= i_cfg_data;
                CFG_Y_HIGH: r_y_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Compares a value with its breakpoints and picks the ramp to divide.
    function automatic t_sel fz_sel(logic [15:0] v, logic [15:0] l,
                                    logic [15:0] m, logic [15:0] h);
        t_sel r;
        r.c.le_l = (v <= l);
        r.c.le_m = (v <= m);
        r.c.le_h = (v <= h);
        if (!r.c.le_l && r.c.le_m) begin
            r.d = m - v;
            r.s = m - l;
        end else if (!r.c.le_m && r.c.le_h) begin
            r.d = h - v;
            r.s = h - m;
        end else begin
            r.d = '0;
            r.s = 16'd1;
        end
        return r;
    endfunction

    // Stage A: breakpoint comparison.
    logic r_a_v;
    t_sel r_a_x, r_a_y;
    logic a_en, d1_ready;

    assign a_en    = !r_a_v || d1_ready;
    assign o_ready = a_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en) begin
            r_a_x <= fz_sel({1'b0, i_x_value}, {1'b0, r_x_low}, {1'b0, r_x_mid},
                            {1'b0, r_x_high});
            r_a_y <= fz_sel(i_y_value, r_y_low, r_y_mid, r_y_high);
        end
    end

    // Ramp divisions for both inputs in lockstep.
    logic [1:0][MEM_DEN_W+QUO_W-1:0] d1_num;
    logic [1:0][MEM_DEN_W-1:0]       d1_den;
    logic [1:0][QUO_W-1:0]           d1_quo;
    logic [5:0]                      d1_side;
    logic                            d1_valid, b_en;

    assign d1_num[0] = {r_a_x.d, {QUO_W{1'b0}}};
    assign d1_num[1] = {r_a_y.d, {QUO_W{1'b0}}};
    assign d1_den[0] = r_a_x.s;
    assign d1_den[1] = r_a_y.s;

    tfi_div #(
        .NL (2),
        .WD (MEM_DEN_W),
        .WQ (QUO_W),
        .WS (6)
    ) u_mem_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .o_ready (d1_ready),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_side  ({r_a_x.c, r_a_y.c}),
        .o_valid (d1_valid),
        .i_ready (b_en),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // Memberships from the comparison flags and the ramp quotient.
    logic [15:0] xl, xm, xh, yl, ym, yh;

    always_comb begin
        t_cmp        cx;
        t_cmp        cy;
        logic [15:0] fx;
        logic [15:0] fy;
        cx = d1_side[5:3];
        cy = d1_side[2:0];
        fx = {1'b0, d1_quo[0]};
        fy = {1'b0, d1_quo[1]};
        xl = cx.le_l ? ONE_Q15 : (cx.le_m ? fx : '0);
        xm = cx.le_l ? '0 : (cx.le_m ? ONE_Q15 - fx : (cx.le_h ? fx : '0));
        xh = cx.le_m ? '0 : (cx.le_h ? ONE_Q15 - fx : ONE_Q15);
        yl = cy.le_l ? ONE_Q15 : (cy.le_m ? fy : '0);
        ym = cy.le_l ? '0 : (cy.le_m ? ONE_Q15 - fy : (cy.le_h ? fy : '0));
        yh = cy.le_m ? '0 : (cy.le_h ? ONE_Q15 - fy : ONE_Q15);
    end

    function automatic logic [15:0] mn(logic [15:0] a, logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [15:0] mx3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        logic [15:0] t;
        t = (a > b) ? a : b;
        return (t > c) ? t : c;
    endfunction

    // Stage B: rule strengths and class aggregation.
    logic        r_b_v;
    logic [15:0] r_b_lo, r_b_md, r_b_hi;
    logic        c_en;

    assign b_en = !r_b_v || c_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_en) begin
            r_b_v <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b_lo <= mx3(mn(xl, yl), mn(xm, yl), mn(xl, ym));
            r_b_md <= mx3(mn(xh, yl), mn(xm, ym), mn(xl, yh));
            r_b_hi <= mx3(mn(xh, ym), mn(xm, yh), mn(xh, yh));
        end
    end

    // Stage C: weighted sum and total strength.
    logic        r_c_v;
    logic [15:0] r_c_lo, r_c_md, r_c_hi;
    logic [22:0] r_c_num;
    logic [16:0] r_c_den;
    logic        d2_ready;

    assign c_en = !r_c_v || d2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (c_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_c_lo  <= r_b_lo;
            r_c_md  <= r_b_md;
            r_c_hi  <= r_b_hi;
            r_c_num <= 23'(r_b_lo) * 23'(SING_LOW) + 23'(r_b_md) * 23'(SING_MID)
                     + 23'(r_b_hi) * 23'(SING_HIGH);
            r_c_den <= 17'(r_b_lo) + 17'(r_b_md) + 17'(r_b_hi);
        end
    end

    // Score division; the score is at most 85 so the quotient fits 15 bits.
    logic [0:0][SCORE_DEN_W+QUO_W-1:0] d2_num;
    logic [0:0][SCORE_DEN_W-1:0]       d2_den;
    logic [0:0][QUO_W-1:0]             d2_quo;
    logic [47:0]                       d2_side;

    assign d2_num[0] = {1'b0, r_c_num, 8'b0};
    assign d2_den[0] = r_c_den;

    tfi_div #(
        .NL (1),
        .WD (SCORE_DEN_W),
        .WQ (QUO_W),
        .WS (48)
    ) u_score_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_v),
        .o_ready (d2_ready),
        .i_num   (d2_num),
        .i_den   (d2_den),
        .i_side  ({r_c_lo, r_c_md, r_c_hi}),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    assign o_low_class_strength  = d2_side[47:32];
    assign o_mid_class_strength  = d2_side[31:16];
    assign o_high_class_strength = d2_side[15:0];
    // With no class firing the score is defined as zero.
    assign o_crisp_score = (|d2_side) ? d2_quo[0] : '0;

`ifndef SYNTHESIS
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_crisp_score <= 15'd21760)
        else $error("crisp score beyond the high singleton");

    a_strength_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_v |-> (r_b_lo <= ONE_Q15 && r_b_md <= ONE_Q15 && r_b_hi <= ONE_Q15))
        else $error("class strength above one");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_a_v)
        else $error("input stalled while the first stage is empty");
`endif

endmodule
